@@ rtl/tpt_pkg.sv @@
package tpt_pkg;

   localparam int COORD_BITS = 24;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int SQ_BITS = 2 * DIFF_BITS;
   localparam int ROOT_BITS = DIFF_BITS + 1;
   localparam int NUM_BITS = DIFF_BITS + NORMAL_FRAC_BITS + 1;
   localparam int NRM_BITS = NORMAL_FRAC_BITS + 2;
   localparam int PROD_BITS = NRM_BITS + 9;
   localparam int OFS_SHIFT = NORMAL_FRAC_BITS - 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] REG_THICKNESS = 2'd0;
   localparam logic [1:0] REG_COLOUR    = 2'd1;
   localparam logic [1:0] REG_VISIBLE   = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type px;
      coord_type py;
      coord_type cx;
      coord_type cy;
      logic      last_seg;
   } seg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_DIV,
      ST_OFS,
      ST_EMIT
   } state_type;

endpackage

@@ rtl/tpt_front.sv @@
module tpt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tpt_pkg::coord_type   req_point_x,
   input  tpt_pkg::coord_type   req_point_y,
   input  logic                 req_last_point,
   input  logic                 req_closed,
   input  logic                 visible,
   output logic                 q_push,
   output tpt_pkg::seg_type     q_data,
   input  logic                 q_room2
);
   tpt_pkg::coord_type first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   tpt_pkg::coord_type first_x_in, first_y_in, prev_x_in, prev_y_in;
   logic [1:0] seen_ff, seen_in;
   logic       pend_ff, pend_in;
   tpt_pkg::seg_type pend_seg_ff, pend_seg_in;
   logic       acc;

   assign req_stall = pend_ff || !q_room2;
   assign acc = req_valid && !req_stall;

   always_comb begin
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      seen_in = seen_ff;
      pend_in = 1'b0;
      pend_seg_in = pend_seg_ff;
      q_push = 1'b0;
      q_data = pend_seg_ff;
      if (pend_ff) begin
         q_push = 1'b1;
      end else if (acc) begin
         prev_x_in = req_point_x;
         prev_y_in = req_point_y;
         if (seen_ff == 2'd0) begin
            first_x_in = req_point_x;
            first_y_in = req_point_y;
         end else if (visible) begin
            q_push = 1'b1;
            q_data.px = prev_x_ff;
            q_data.py = prev_y_ff;
            q_data.cx = req_point_x;
            q_data.cy = req_point_y;
            q_data.last_seg = !(req_last_point && req_closed);
            pend_in = req_last_point && req_closed;
            pend_seg_in.px = req_point_x;
            pend_seg_in.py = req_point_y;
            pend_seg_in.cx = first_x_ff;
            pend_seg_in.cy = first_y_ff;
            pend_seg_in.last_seg = 1'b1;
         end
         if (req_last_point) seen_in = 2'd0;
         else if (seen_ff != 2'd2) seen_in = seen_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         seen_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         seen_ff <= seen_in;
         pend_ff <= pend_in;
      end
      pend_seg_ff <= pend_seg_in;
   end

`ifndef SYNTHESIS
   a_pend_push: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> q_push) else $error("pending closing segment not pushed");
   a_pend_stall: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> req_stall) else $error("accept while closing pending");
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff != 2'd3) else $error("points_seen overflow");
`endif
endmodule

@@ rtl/tpt_queue.sv @@
module tpt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tpt_pkg::seg_type  push_data,
   output logic              room2,
   output logic              pop_valid,
   input  logic              pop,
   output tpt_pkg::seg_type  pop_data
);
   localparam int PW = tpt_pkg::QPTR_BITS;
   tpt_pkg::seg_type mem_ff [tpt_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic do_pop;

   assign do_pop = pop && pop_valid;
   assign pop_valid = cnt_ff != '0;
   assign pop_data = mem_ff[rd_ff];
   assign room2 = cnt_ff == '0;

   always_comb begin
      wr_in = push ? wr_ff + PW'(1) : wr_ff;
      rd_in = do_pop ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

`ifndef SYNTHESIS
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      !(push && !do_pop && cnt_ff == (PW+1)'(tpt_pkg::QUEUE_DEPTH)))
      else $error("queue overflow");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> cnt_ff == $past(cnt_ff) + (PW+1)'(1))
      else $error("queue count");
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(tpt_pkg::QUEUE_DEPTH)) else $error("queue count range");
`endif
endmodule

@@ rtl/tpt_back.sv @@
module tpt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                seg_valid,
   output logic                seg_pop,
   input  tpt_pkg::seg_type    seg,
   input  logic [7:0]          thickness,
   input  logic [31:0]         colour,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tpt_pkg::coord_type  rsp_vertex_x,
   output tpt_pkg::coord_type  rsp_vertex_y,
   output logic [31:0]         rsp_vertex_colour,
   output logic                rsp_last_vertex,
   output logic                busy
);
   localparam int DB = tpt_pkg::DIFF_BITS;
   localparam int SB = tpt_pkg::SQ_BITS;
   localparam int RB = tpt_pkg::ROOT_BITS;
   localparam int NB = tpt_pkg::NUM_BITS;
   localparam int MB = tpt_pkg::NRM_BITS;
   localparam int PB = tpt_pkg::PROD_BITS;
   localparam int CB = tpt_pkg::COORD_BITS;
   localparam int XB = CB + 2;
   localparam int RCB = $clog2(SB / 2 + 1);
   localparam int DCB = $clog2(NB + 1);
   localparam logic signed [XB-1:0] CMAX = XB'((64'sd1 <<< (CB - 1)) - 1);
   localparam logic signed [XB-1:0] CMIN = -CMAX - XB'(1);

   tpt_pkg::state_type st_ff, st_in;
   tpt_pkg::seg_type sg_ff;
   logic [DB-1:0] ax_ff, ay_ff;
   logic dxn_ff, dyp_ff;
   logic [SB-1:0] rem_ff, sq_ff;
   logic [RB-1:0] root_ff;
   logic [RCB-1:0] rcnt_ff;
   logic [NB-1:0] numx_ff, numy_ff;
   logic [RB+1:0] remx_ff, remy_ff;
   logic [MB-1:0] qx_ff, qy_ff;
   logic [DCB-1:0] dcnt_ff;
   logic signed [XB-1:0] ox_ff, oy_ff;
   logic [2:0] vi_ff;
   logic v_ff, vl_ff;
   tpt_pkg::coord_type vx_ff, vy_ff;

   logic signed [DB-1:0] dx, dy;
   logic [SB+1:0] trial;
   logic [RB+1:0] rx_sh, ry_sh;
   logic [PB-1:0] px, py;
   logic [PB-1:0] mxr, myr;
   logic signed [XB-1:0] sx, sy, vxw, vyw;
   logic out_free, emit;

   assign out_free = !v_ff || !rsp_stall;
   assign busy = st_ff != tpt_pkg::ST_IDLE || v_ff;
   assign dx = DB'(sg_ff.cx) - DB'(sg_ff.px);
   assign dy = DB'(sg_ff.cy) - DB'(sg_ff.py);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         tpt_pkg::ST_IDLE: if (seg_valid) st_in = tpt_pkg::ST_SQRT;
         tpt_pkg::ST_SQRT: if (rcnt_ff == '0) st_in = tpt_pkg::ST_DIV;
         tpt_pkg::ST_DIV:  if (dcnt_ff == '0) st_in = tpt_pkg::ST_OFS;
         tpt_pkg::ST_OFS:  st_in = tpt_pkg::ST_EMIT;
         tpt_pkg::ST_EMIT: if (out_free && vi_ff == 3'd5) st_in = tpt_pkg::ST_IDLE;
         default:          st_in = tpt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      seg_pop = st_ff == tpt_pkg::ST_IDLE && seg_valid;
      emit = st_ff == tpt_pkg::ST_EMIT && out_free;
      trial = {rem_ff[SB-1:0], sq_ff[SB-1 -: 2]} - {{(SB - RB){1'b0}}, root_ff, 2'b01};
      rx_sh = {remx_ff[RB:0], numx_ff[NB-1]};
      ry_sh = {remy_ff[RB:0], numy_ff[NB-1]};
      mxr = PB'(qx_ff) * PB'(thickness);
      myr = PB'(qy_ff) * PB'(thickness);
      px = (mxr + PB'(1 << (tpt_pkg::OFS_SHIFT - 1))) >> tpt_pkg::OFS_SHIFT;
      py = (myr + PB'(1 << (tpt_pkg::OFS_SHIFT - 1))) >> tpt_pkg::OFS_SHIFT;
      case (vi_ff)
         3'd1, 3'd5: begin
            sx = XB'(sg_ff.cx) - ox_ff; sy = XB'(sg_ff.cy) - oy_ff;
         end
         3'd2: begin
            sx = XB'(sg_ff.px) - ox_ff; sy = XB'(sg_ff.py) - oy_ff;
         end
         3'd4: begin
            sx = XB'(sg_ff.cx) + ox_ff; sy = XB'(sg_ff.cy) + oy_ff;
         end
         default: begin
            sx = XB'(sg_ff.px) + ox_ff; sy = XB'(sg_ff.py) + oy_ff;
         end
      endcase
      vxw = sx > CMAX ? CMAX : (sx < CMIN ? CMIN : sx);
      vyw = sy > CMAX ? CMAX : (sy < CMIN ? CMIN : sy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= tpt_pkg::ST_IDLE;
         v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (emit) v_ff <= 1'b1;
         else if (!rsp_stall) v_ff <= 1'b0;
      end
      case (st_ff)
         tpt_pkg::ST_IDLE: begin
            sg_ff <= seg;
            rcnt_ff <= RCB'(SB / 2);
            root_ff <= '0;
            rem_ff <= '0;
         end
         tpt_pkg::ST_SQRT: begin
            if (rcnt_ff == RCB'(SB / 2)) begin
               ax_ff <= dx[DB-1] ? DB'(-dx) : DB'(dx);
               ay_ff <= dy[DB-1] ? DB'(-dy) : DB'(dy);
               dxn_ff <= dx[DB-1];
               dyp_ff <= !dy[DB-1] && dy != '0;
               sq_ff <= SB'((dx[DB-1] ? DB'(-dx) : DB'(dx)) * (dx[DB-1] ? DB'(-dx) : DB'(dx)))
                      + SB'((dy[DB-1] ? DB'(-dy) : DB'(dy)) * (dy[DB-1] ? DB'(-dy) : DB'(dy)));
               rcnt_ff <= rcnt_ff - RCB'(1);
            end else begin
               if (!trial[SB+1]) begin
                  rem_ff <= SB'(trial);
                  root_ff <= {root_ff[RB-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[SB-3:0], sq_ff[SB-1 -: 2]};
                  root_ff <= {root_ff[RB-2:0], 1'b0};
               end
               sq_ff <= {sq_ff[SB-3:0], 2'b00};
               if (rcnt_ff != '0) rcnt_ff <= rcnt_ff - RCB'(1);
               numx_ff <= (NB'(ay_ff) << tpt_pkg::NORMAL_FRAC_BITS);
               numy_ff <= (NB'(ax_ff) << tpt_pkg::NORMAL_FRAC_BITS);
               dcnt_ff <= DCB'(NB);
            end
         end
         tpt_pkg::ST_DIV: begin
            if (dcnt_ff == DCB'(NB)) begin
               numx_ff <= numx_ff + NB'(root_ff >> 1);
               numy_ff <= numy_ff + NB'(root_ff >> 1);
               remx_ff <= '0;
               remy_ff <= '0;
            end else begin
               numx_ff <= {numx_ff[NB-2:0], rx_sh >= (RB+2)'(root_ff)};
               numy_ff <= {numy_ff[NB-2:0], ry_sh >= (RB+2)'(root_ff)};
               remx_ff <= rx_sh >= (RB+2)'(root_ff) ? rx_sh - (RB+2)'(root_ff) : rx_sh;
               remy_ff <= ry_sh >= (RB+2)'(root_ff) ? ry_sh - (RB+2)'(root_ff) : ry_sh;
            end
            dcnt_ff <= dcnt_ff - DCB'(1);
         end
         tpt_pkg::ST_OFS: begin
            vi_ff <= '0;
         end
         default: begin
            if (emit) vi_ff <= vi_ff + 3'd1;
         end
      endcase
      if (st_ff == tpt_pkg::ST_DIV && dcnt_ff == '0) begin
         qx_ff <= root_ff == '0 ? '0 :
                  MB'({numx_ff[NB-2:0], rx_sh >= (RB+2)'(root_ff)});
         qy_ff <= root_ff == '0 ? '0 :
                  MB'({numy_ff[NB-2:0], ry_sh >= (RB+2)'(root_ff)});
      end
      if (st_ff == tpt_pkg::ST_OFS) begin
         ox_ff <= dyp_ff ? -XB'(px) : XB'(px);
         oy_ff <= dxn_ff ? -XB'(py) : XB'(py);
      end
      if (emit) begin
         vx_ff <= CB'(vxw);
         vy_ff <= CB'(vyw);
         vl_ff <= vi_ff == 3'd5 && sg_ff.last_seg;
      end
   end

   assign rsp_valid = v_ff;
   assign rsp_vertex_x = vx_ff;
   assign rsp_vertex_y = vy_ff;
   assign rsp_vertex_colour = colour;
   assign rsp_last_vertex = vl_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff && rsp_stall) |=> v_ff && $stable(vx_ff)) else $error("stalled vertex lost");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      seg_pop |-> st_ff == tpt_pkg::ST_IDLE) else $error("pop while busy");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      emit |-> vi_ff <= 3'd5) else $error("vertex index range");
`endif
endmodule

@@ rtl/thick_polyline_to_triangles_core.sv @@
// Thick polyline expander: while visible, each accepted point after the first
// of a polyline yields six vertices (two triangles), twelve on the last point
// of a closed polyline. The back end handles one segment at a time: it takes
// it from the queue, runs a bit-serial square root (one result bit a cycle),
// then a bit-serial restoring divide for both normal components, computes the
// offset, then emits six vertices, holding each while rsp_stall is high. The
// front end takes a point whenever the segment queue is empty and no closing
// segment is waiting. Configure only while idle.
module thick_polyline_to_triangles_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tpt_pkg::coord_type  req_point_x,
   input  tpt_pkg::coord_type  req_point_y,
   input  logic                req_last_point,
   input  logic                req_closed,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tpt_pkg::coord_type  rsp_vertex_x,
   output tpt_pkg::coord_type  rsp_vertex_y,
   output logic [31:0]         rsp_vertex_colour,
   output logic                rsp_last_vertex,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   logic [7:0]  thick_ff;
   logic [31:0] colour_ff;
   logic        vis_ff;
   logic q_push, q_room2, q_valid, q_pop, busy;
   tpt_pkg::seg_type q_in, q_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thick_ff <= 8'd1;
         colour_ff <= 32'hFFFF_FFFF;
         vis_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            tpt_pkg::REG_THICKNESS: thick_ff <= csr_data[7:0];
            tpt_pkg::REG_COLOUR:    colour_ff <= csr_data;
            tpt_pkg::REG_VISIBLE:   vis_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   tpt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_point_x, .req_point_y,
      .req_last_point, .req_closed, .visible(vis_ff),
      .q_push, .q_data(q_in), .q_room2
   );

   tpt_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .room2(q_room2),
      .pop_valid(q_valid), .pop(q_pop), .pop_data(q_out)
   );

   tpt_back u_back (
      .clock, .reset, .seg_valid(q_valid), .seg_pop(q_pop), .seg(q_out),
      .thickness(thick_ff), .colour(colour_ff),
      .rsp_valid, .rsp_stall, .rsp_vertex_x, .rsp_vertex_y,
      .rsp_vertex_colour, .rsp_last_vertex, .busy
   );

`ifndef SYNTHESIS
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !busy && !q_valid) else $error("write while busy");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> q_room2) else $error("accept without room");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_vertex_x)
         && $stable(rsp_vertex_y) && $stable(rsp_last_vertex))
      else $error("stalled vertex changed");
`endif
endmodule
